/* src/smcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcg_pkg
// Shared types and constants of the sphere mesh cell generator.
// ----------------------------------------------------------------------------
package smcg_pkg;

    // field widths
    localparam int RADIUS_W = 16;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 17;
    localparam int TEX_W    = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // texture value of 1.0 in Q1.16
    localparam int TEX_ONE = 65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 2'd2;

    // quotient lanes of the front end
    localparam int LANES   = 8;
    localparam int LANE_B0 = 0;
    localparam int LANE_B1 = 1;
    localparam int LANE_T0 = 2;
    localparam int LANE_T1 = 3;
    localparam int LANE_A0 = 4;
    localparam int LANE_A1 = 5;
    localparam int LANE_S0 = 6;
    localparam int LANE_S1 = 7;
    // lanes below this one divide by the stack count
    localparam int LANE_SLICE_FIRST = 4;

    // sine series constants, Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // live configuration plus the write strobe
    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [COUNT_W-1:0]  slice_count;
        logic [COUNT_W-1:0]  stack_count;
        logic                write;
    } t_cfg;

    // texture part and triangle flags of one cell
    typedef struct packed {
        logic [TEX_W-1:0] s0;
        logic [TEX_W-1:0] s1;
        logic [TEX_W-1:0] t0;
        logic [TEX_W-1:0] t1;
        logic             lower;
        logic             upper;
    } t_tex_info;

endpackage

/* src/smcg_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcg_queue
// Four-entry queue of cell records between the front and back ends.
// ----------------------------------------------------------------------------
module smcg_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W:0]    r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/smcg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcg_front
// Accepts cells, checks range, and works out angle phases and texture
// coordinates through reciprocal multiplication with one correction step.
// ----------------------------------------------------------------------------
module smcg_front #(
    parameter int MAX_SLICES       = 256,
    parameter int MAX_STACKS       = 256,
    parameter int SINE_TABLE_DEPTH = 1024,
    localparam int AW = $clog2(4 * SINE_TABLE_DEPTH + 1),
    localparam int REC_W = 4 * AW + $bits(smcg_pkg::t_tex_info)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smcg_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [smcg_pkg::INDEX_W-1:0]  i_stack_index,
    input  logic [smcg_pkg::INDEX_W-1:0]  i_slice_index,
    output logic                          o_push,
    output logic [REC_W-1:0]              o_rec,
    input  logic                          i_full
);
    import smcg_pkg::*;

    localparam int QW = (AW > TEX_W) ? AW : TEX_W;
    localparam int MB = 4 * SINE_TABLE_DEPTH;
    localparam int MA = 8 * SINE_TABLE_DEPTH;
    localparam int MT = 2 * TEX_ONE;
    localparam int NUM_MAX = ((MA > MT) ? MA : MT) * (1 << INDEX_W) + (1 << COUNT_W);
    localparam int NW = $clog2(NUM_MAX + 1);
    localparam int DW = COUNT_W + 1;
    localparam int CW = $clog2(NW + 1);
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] SL_CAP =
        COUNT_W'((MAX_SLICES > COUNT_MAX) ? COUNT_MAX : MAX_SLICES);
    localparam logic [COUNT_W-1:0] ST_CAP =
        COUNT_W'((MAX_STACKS > COUNT_MAX) ? COUNT_MAX : MAX_STACKS);

    // clamped counts and divisors (twice the count)
    logic [COUNT_W-1:0] sl;
    logic [COUNT_W-1:0] st;
    logic [DW-1:0]      ds;
    logic [DW-1:0]      dt;

    assign sl = (i_cfg.slice_count > SL_CAP) ? SL_CAP : i_cfg.slice_count;
    assign st = (i_cfg.stack_count > ST_CAP) ? ST_CAP : i_cfg.stack_count;
    assign ds = {sl, 1'b0};
    assign dt = {st, 1'b0};

    // reciprocal unit: floor(2^NW / divisor), one bit a cycle
    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem_s;
    logic [DW-1:0] r_rem_t;
    logic [NW-1:0] r_recip_s;
    logic [NW-1:0] r_recip_t;
    logic          bit_in;
    logic [DW:0]   sh_s;
    logic [DW:0]   sh_t;
    logic          ge_s;
    logic          ge_t;

    always_comb begin
        bit_in = (r_cnt == '0);
        sh_s   = {r_rem_s, bit_in};
        sh_t   = {r_rem_t, bit_in};
        ge_s   = (sh_s >= {1'b0, ds});
        ge_t   = (sh_t >= {1'b0, dt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_rem_s <= '0;
            r_rem_t <= '0;
        end else if (i_cfg.write) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_rem_s <= '0;
            r_rem_t <= '0;
        end else if (r_busy) begin
            r_rem_s <= ge_s ? DW'(sh_s - {1'b0, ds}) : DW'(sh_s);
            r_rem_t <= ge_t ? DW'(sh_t - {1'b0, dt}) : DW'(sh_t);
            r_cnt   <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_recip_s <= {r_recip_s[NW-2:0], ge_s};
            r_recip_t <= {r_recip_t[NW-2:0], ge_t};
        end
    end

    // pipeline enable: hold when the finished record cannot enter the queue
    logic r_s4_valid;
    logic fe;
    logic accept;

    assign fe         = !r_s4_valid || !i_full;
    assign o_in_stall = r_busy || !fe;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s4_valid && !i_full;

    // classify the cell and form numerators
    logic [COUNT_W-1:0] ie;
    logic [COUNT_W-1:0] je;
    logic               in_range;
    logic               lower;
    logic               upper;
    logic [NW-1:0]      num [LANES];

    always_comb begin
        ie       = COUNT_W'(i_stack_index);
        je       = COUNT_W'(i_slice_index);
        in_range = (sl != '0) && (st != '0) && (ie < st) && (je < sl);
        lower    = ((ie + 1'b1) < st);
        upper    = (ie != '0);
        num[LANE_B0] = NW'(ie) * NW'(MB) + NW'(st);
        num[LANE_B1] = NW'(ie + 1'b1) * NW'(MB) + NW'(st);
        num[LANE_T0] = NW'(st - ie) * NW'(MT) + NW'(st);
        num[LANE_T1] = NW'(st - ie - 1'b1) * NW'(MT) + NW'(st);
        num[LANE_A0] = NW'(je) * NW'(MA) + NW'(sl);
        num[LANE_A1] = NW'(je + 1'b1) * NW'(MA) + NW'(sl);
        num[LANE_S0] = NW'(je) * NW'(MT) + NW'(sl);
        num[LANE_S1] = NW'(je + 1'b1) * NW'(MT) + NW'(sl);
    end

    // per-lane divisor and reciprocal
    logic [DW-1:0] d2    [LANES];
    logic [NW-1:0] recip [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            d2[k]    = (k < LANE_SLICE_FIRST) ? dt : ds;
            recip[k] = (k < LANE_SLICE_FIRST) ? r_recip_t : r_recip_s;
        end
    end

    // pipeline registers
    logic               r_s1_valid;
    logic [NW-1:0]      r_s1_num  [LANES];
    logic [1:0]         r_s1_flag;
    logic               r_s2_valid;
    logic [2*NW-1:0]    r_s2_prod [LANES];
    logic [NW-1:0]      r_s2_num  [LANES];
    logic [1:0]         r_s2_flag;
    logic               r_s3_valid;
    logic [QW-1:0]      r_s3_qp   [LANES];
    logic [QW+DW-1:0]   r_s3_qd   [LANES];
    logic [NW-1:0]      r_s3_num  [LANES];
    logic [1:0]         r_s3_flag;
    logic [QW-1:0]      r_s4_q    [LANES];
    logic [1:0]         r_s4_flag;
    logic [QW-1:0]      qp        [LANES];
    logic               cor       [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            qp[k]  = QW'(r_s2_prod[k][2*NW-1:NW]);
            cor[k] = ((NW + 1)'(r_s3_qd[k]) + (NW + 1)'(d2[k])) <= (NW + 1)'(r_s3_num[k]);
        end
    end

    // advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (fe) begin
            r_s1_valid <= accept && in_range && (lower || upper);
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // advance payload: multiply by reciprocal, back-multiply, correct
    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_s1_flag <= {lower, upper};
            r_s2_flag <= r_s1_flag;
            r_s3_flag <= r_s2_flag;
            r_s4_flag <= r_s3_flag;
            for (int k = 0; k < LANES; k++) begin
                r_s1_num[k]  <= num[k];
                r_s2_prod[k] <= (2 * NW)'(r_s1_num[k]) * (2 * NW)'(recip[k]);
                r_s2_num[k]  <= r_s1_num[k];
                r_s3_qp[k]   <= qp[k];
                r_s3_qd[k]   <= (QW + DW)'(qp[k]) * (QW + DW)'(d2[k]);
                r_s3_num[k]  <= r_s2_num[k];
                r_s4_q[k]    <= r_s3_qp[k] + QW'(cor[k]);
            end
        end
    end

    // pack the record
    t_tex_info tex;

    always_comb begin
        tex.s0    = TEX_W'(r_s4_q[LANE_S0]);
        tex.s1    = TEX_W'(r_s4_q[LANE_S1]);
        tex.t0    = TEX_W'(r_s4_q[LANE_T0]);
        tex.t1    = TEX_W'(r_s4_q[LANE_T1]);
        tex.lower = r_s4_flag[1];
        tex.upper = r_s4_flag[0];
        o_rec = {AW'(r_s4_q[LANE_A1]), AW'(r_s4_q[LANE_A0]),
                 AW'(r_s4_q[LANE_B1]), AW'(r_s4_q[LANE_B0]), tex};
    end

endmodule

/* src/smcg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcg_back
// Walks the vertices of each cell record, looks up sines and forms the
// rounded fixed-point positions, one vertex a cycle unless stalled.
// ----------------------------------------------------------------------------
module smcg_back #(
    parameter int SINE_TABLE_DEPTH = 1024,
    localparam int AW = $clog2(4 * SINE_TABLE_DEPTH + 1),
    localparam int REC_W = 4 * AW + $bits(smcg_pkg::t_tex_info)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [smcg_pkg::RADIUS_W-1:0]       i_radius,
    input  logic                                i_q_valid,
    input  logic [REC_W-1:0]                    i_q_data,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [smcg_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [smcg_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [smcg_pkg::POS_W-1:0]   o_pos_z,
    output logic [smcg_pkg::TEX_W-1:0]          o_tex_s,
    output logic [smcg_pkg::TEX_W-1:0]          o_tex_t,
    output logic                                o_last_vertex
);
    import smcg_pkg::*;

    localparam int D    = SINE_TABLE_DEPTH;
    localparam int PW   = $clog2(5 * D + 1);
    localparam int ADW  = $clog2(D + 1);
    localparam int MW   = TEX_W;
    localparam int PXW  = 2 * MW;
    localparam int PYW  = RADIUS_W + MW;
    localparam int SEL_SB = 0;
    localparam int SEL_CB = 1;
    localparam int SEL_SA = 2;
    localparam int SEL_CA = 3;

    // quarter-wave sine table, Q1.16, from a Q30 series
    function automatic logic [D:0][MW-1:0] build_sine_rom();
        logic [D:0][MW-1:0] rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= D; k++) begin
            x    = (64'(k) * PI_Q30 * 64'd2 + 64'(2 * SINE_TABLE_DEPTH))
                   / 64'(4 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[n-1];
                if (n % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            v = (unsigned'(sum) + 64'd8192) >> 14;
            if (v > 64'(TEX_ONE)) begin
                v = 64'(TEX_ONE);
            end
            rom[k] = MW'(v);
        end
        return rom;
    endfunction

    localparam logic [D:0][MW-1:0] SINE_ROM_B = build_sine_rom();
    localparam logic [D:0][MW-1:0] SINE_ROM_A = build_sine_rom();

    // phase to {negate, table address}
    function automatic logic [ADW:0] phase_lookup(input logic [PW-1:0] phase);
        logic [PW-1:0]  p;
        logic [PW-1:0]  r;
        logic [1:0]     q;
        logic [ADW-1:0] addr;
        p = (phase >= PW'(4 * D)) ? phase - PW'(4 * D) : phase;
        if (p >= PW'(3 * D)) begin
            q = 2'd3;
            r = p - PW'(3 * D);
        end else if (p >= PW'(2 * D)) begin
            q = 2'd2;
            r = p - PW'(2 * D);
        end else if (p >= PW'(D)) begin
            q = 2'd1;
            r = p - PW'(D);
        end else begin
            q = 2'd0;
            r = p;
        end
        addr = q[0] ? ADW'(PW'(D) - r) : ADW'(r);
        return {q[1], addr};
    endfunction

    // whole pipeline holds while the output is stalled
    logic r_out_valid;
    logic be;

    assign be          = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // current cell record and vertex slot
    logic [REC_W-1:0] r_cur;
    logic             r_cur_valid;
    logic [2:0]       r_vidx;
    logic [AW-1:0]    b0, b1, a0, a1;
    t_tex_info        tex;
    t_tex_info        q_tex;
    logic             cur_last;
    logic             load;

    always_comb begin
        {a1, a0, b1, b0, tex} = r_cur;
        q_tex    = t_tex_info'(i_q_data[$bits(t_tex_info)-1:0]);
        cur_last = (r_vidx == (tex.upper ? 3'd5 : 3'd2));
        load     = be && i_q_valid && (!r_cur_valid || cur_last);
        o_pop    = load;
    end

    // step through the cell's vertices, fetch the next record at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_vidx      <= '0;
        end else if (be) begin
            if (load) begin
                r_cur_valid <= 1'b1;
                r_vidx      <= q_tex.lower ? 3'd0 : 3'd3;
            end else if (r_cur_valid && cur_last) begin
                r_cur_valid <= 1'b0;
            end else if (r_cur_valid) begin
                r_vidx <= r_vidx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_data;
        end
    end

    // select the corner of this vertex and map phases to table addresses
    logic          use_b1;
    logic          use_a1;
    logic [PW-1:0] bph;
    logic [PW-1:0] aph;
    logic [ADW:0]  lk [4];

    always_comb begin
        use_b1 = (r_vidx == 3'd1) || (r_vidx == 3'd2) || (r_vidx == 3'd4);
        use_a1 = (r_vidx == 3'd2) || (r_vidx == 3'd4) || (r_vidx == 3'd5);
        bph    = PW'(use_b1 ? b1 : b0);
        aph    = PW'(use_a1 ? a1 : a0);
        lk[SEL_SB] = phase_lookup(bph);
        lk[SEL_CB] = phase_lookup(bph + PW'(D));
        lk[SEL_SA] = phase_lookup(aph);
        lk[SEL_CA] = phase_lookup(aph + PW'(D));
    end

    // stage registers
    logic             r_v_valid;
    logic [ADW-1:0]   r_v_addr [4];
    logic [3:0]       r_v_neg;
    logic [TEX_W-1:0] r_v_s, r_v_t;
    logic             r_v_last;
    logic             r_r_valid;
    logic [MW-1:0]    r_r_mag [4];
    logic [3:0]       r_r_neg;
    logic [TEX_W-1:0] r_r_s, r_r_t;
    logic             r_r_last;
    logic             r_p_valid;
    logic [PXW-1:0]   r_p_x, r_p_z;
    logic [PYW-1:0]   r_p_y;
    logic [2:0]       r_p_neg;
    logic [TEX_W-1:0] r_p_s, r_p_t;
    logic             r_p_last;
    logic             r_q_valid;
    logic [PYW-1:0]   r_q_x, r_q_z;
    logic [MW-1:0]    r_q_y;
    logic [2:0]       r_q_neg;
    logic [TEX_W-1:0] r_q_s, r_q_t;
    logic             r_q_last;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [TEX_W-1:0] r_tex_s, r_tex_t;
    logic             r_last;

    // rounded products
    logic [MW-1:0] vx, vz, vy;
    logic [MW-1:0] mx, mz;

    always_comb begin
        vx = MW'((r_p_x + PXW'(32768)) >> 16);
        vz = MW'((r_p_z + PXW'(32768)) >> 16);
        vy = MW'((r_p_y + PYW'(32768)) >> 16);
        mx = MW'((r_q_x + PYW'(32768)) >> 16);
        mz = MW'((r_q_z + PYW'(32768)) >> 16);
    end

    // advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid   <= 1'b0;
            r_r_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (be) begin
            r_v_valid   <= r_cur_valid;
            r_r_valid   <= r_v_valid;
            r_p_valid   <= r_r_valid;
            r_q_valid   <= r_p_valid;
            r_out_valid <= r_q_valid;
        end
    end

    // issue addresses and texture of the vertex
    always_ff @(posedge i_clk) begin
        if (be) begin
            for (int k = 0; k < 4; k++) begin
                r_v_addr[k] <= lk[k][ADW-1:0];
                r_v_neg[k]  <= lk[k][ADW];
            end
            r_v_s    <= use_a1 ? tex.s1 : tex.s0;
            r_v_t    <= use_b1 ? tex.t1 : tex.t0;
            r_v_last <= cur_last;
        end
    end

    // read the sine tables, two addresses each
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_r_mag[SEL_SB] <= SINE_ROM_B[r_v_addr[SEL_SB]];
            r_r_mag[SEL_CB] <= SINE_ROM_B[r_v_addr[SEL_CB]];
            r_r_mag[SEL_SA] <= SINE_ROM_A[r_v_addr[SEL_SA]];
            r_r_mag[SEL_CA] <= SINE_ROM_A[r_v_addr[SEL_CA]];
        end
    end

    // multiply magnitudes, carry signs, round and scale, then restore sign
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_r_neg  <= r_v_neg;
            r_r_s    <= r_v_s;
            r_r_t    <= r_v_t;
            r_r_last <= r_v_last;

            r_p_x    <= PXW'(r_r_mag[SEL_SB]) * PXW'(r_r_mag[SEL_SA]);
            r_p_z    <= PXW'(r_r_mag[SEL_SB]) * PXW'(r_r_mag[SEL_CA]);
            r_p_y    <= PYW'(i_radius) * PYW'(r_r_mag[SEL_CB]);
            r_p_neg  <= {r_r_neg[SEL_SB] ^ r_r_neg[SEL_CA], r_r_neg[SEL_CB],
                         r_r_neg[SEL_SB] ^ r_r_neg[SEL_SA]};
            r_p_s    <= r_r_s;
            r_p_t    <= r_r_t;
            r_p_last <= r_r_last;

            r_q_x    <= PYW'(i_radius) * PYW'(vx);
            r_q_z    <= PYW'(i_radius) * PYW'(vz);
            r_q_y    <= vy;
            r_q_neg  <= r_p_neg;
            r_q_s    <= r_p_s;
            r_q_t    <= r_p_t;
            r_q_last <= r_p_last;

            r_pos_x  <= r_q_neg[0] ? signed'(POS_W'(-mx)) : signed'(POS_W'(mx));
            r_pos_y  <= r_q_neg[1] ? signed'(POS_W'(-r_q_y)) : signed'(POS_W'(r_q_y));
            r_pos_z  <= r_q_neg[2] ? signed'(POS_W'(-mz)) : signed'(POS_W'(mz));
            r_tex_s  <= r_q_s;
            r_tex_t  <= r_q_t;
            r_last   <= r_q_last;
        end
    end

    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_tex_s       = r_tex_s;
    assign o_tex_t       = r_tex_t;
    assign o_last_vertex = r_last;

endmodule

/* src/sphere_mesh_cell_generator_unit.sv */
`timescale 1ns / 1ps
// A cell passes front stages s1 to s4, the queue, the current record and back
// stages v, r, p, q and out. The output gives one vertex a cycle unless stalled,
// 3 or 6 vertices per cell; the output vertex rate is the limit, the front end
// takes a cell every cycle unless it stalls. Reset and every configuration
// write start the reciprocal refresh, stalling the input. Out-of-range cells drop.
// ----------------------------------------------------------------------------
// sphere_mesh_cell_generator_unit
// UV sphere cell tessellator: configuration registers, front end, record
// queue and vertex back end.
// ----------------------------------------------------------------------------
module sphere_mesh_cell_generator_unit #(
    parameter int MAX_SLICES       = 256,
    parameter int MAX_STACKS       = 256,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smcg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smcg_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [smcg_pkg::INDEX_W-1:0]        i_stack_index,
    input  logic [smcg_pkg::INDEX_W-1:0]        i_slice_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [smcg_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [smcg_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [smcg_pkg::POS_W-1:0]   o_pos_z,
    output logic [smcg_pkg::TEX_W-1:0]          o_tex_s,
    output logic [smcg_pkg::TEX_W-1:0]          o_tex_t,
    output logic                                o_last_vertex
);
    import smcg_pkg::*;

    localparam int AW = $clog2(4 * SINE_TABLE_DEPTH + 1);
    localparam int REC_W = 4 * AW + $bits(t_tex_info);

    // configuration registers
    logic [RADIUS_W-1:0] r_radius;
    logic [COUNT_W-1:0]  r_slice_count;
    logic [COUNT_W-1:0]  r_stack_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_W'(256);
            r_slice_count <= COUNT_W'(16);
            r_stack_count <= COUNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS:      r_radius      <= i_cfg_data;
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[COUNT_W-1:0];
                CFG_STACK_COUNT: r_stack_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    t_cfg cfg;

    always_comb begin
        cfg.radius      = r_radius;
        cfg.slice_count = r_slice_count;
        cfg.stack_count = r_stack_count;
        cfg.write       = i_cfg_we;
    end

    logic             push;
    logic [REC_W-1:0] rec;
    logic             full;
    logic             q_valid;
    logic [REC_W-1:0] q_data;
    logic             pop;

    smcg_front #(
        .MAX_SLICES       (MAX_SLICES),
        .MAX_STACKS       (MAX_STACKS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stack_index (i_stack_index),
        .i_slice_index (i_slice_index),
        .o_push        (push),
        .o_rec         (rec),
        .i_full        (full)
    );

    smcg_queue #(
        .DATA_W (REC_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (rec),
        .o_full      (full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (pop)
    );

    smcg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_radius      (cfg.radius),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_tex_s       (o_tex_s),
        .o_tex_t       (o_tex_t),
        .o_last_vertex (o_last_vertex)
    );

endmodule
